/* sv/cpsl_pkg.sv */
// Shared types, widths and constants for the charger PID with safety latch.
`timescale 1ns / 1ps

package cpsl_pkg;

    localparam int GAIN_W     = 24;
    localparam int CELL_W     = 13;
    localparam int CHG_MA_W   = 12;
    localparam int TEMP_W     = 10;
    localparam int MV_W       = 15;
    localparam int MA_W       = 13;
    localparam int TGT_MA_W   = 12;
    localparam int FUNC_W     = 2;
    localparam int DUTY_W     = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam int ERR_W   = MV_W + 2;     // target - bus, signed
    localparam int DERIV_W = ERR_W + 1;    // error - previous error
    localparam int INTEG_W = 19;           // holds +-255000
    localparam int SUM_W   = GAIN_W + INTEG_W + 2;

    // operation codes
    localparam logic [FUNC_W-1:0] FUNC_REGULATE = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_CHECK    = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_RESET    = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_KP         = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KI         = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KD         = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_CELL   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_CELL   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_CHARGE = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_TEMP_LIMIT = 3'd6;

    localparam logic [CELL_W-1:0]   MAX_CELL_RST   = 13'd4200;
    localparam logic [CELL_W-1:0]   MIN_CELL_RST   = 13'd3000;
    localparam logic [CHG_MA_W-1:0] MAX_CHARGE_RST = 12'd1000;
    localparam logic [TEMP_W-1:0]   TEMP_LIMIT_RST = 10'd1023;

    localparam logic signed [INTEG_W:0] INTEG_LIMIT     = 20'sd255000;
    localparam logic [MV_W-1:0]         CONNECT_MIN_MV  = 15'd500;
    localparam logic [DUTY_W-1:0]       DUTY_MAX        = 8'd255;
    localparam logic [DUTY_W-1:0]       OVERCURRENT_STEP = 8'd10;

    typedef struct packed {
        logic [GAIN_W-1:0]   kp_gain;
        logic [GAIN_W-1:0]   ki_gain;
        logic [GAIN_W-1:0]   kd_gain;
        logic [CELL_W-1:0]   max_cell_mv;
        logic [CELL_W-1:0]   min_cell_mv;
        logic [CHG_MA_W-1:0] max_charge_ma;
        logic [TEMP_W-1:0]   temp_limit_code;
    } t_cfg;

    typedef struct packed {
        logic [FUNC_W-1:0]   func;
        logic [MV_W-1:0]     bus_mv;
        logic [MA_W-1:0]     current_ma;
        logic [TEMP_W-1:0]   temp_code;
        logic [MV_W-1:0]     target_mv;
        logic [TGT_MA_W-1:0] target_ma;
    } t_item;

    typedef struct packed {
        logic [DUTY_W-1:0] duty;
        logic              duty_valid;
        logic              safe_flag;
        logic              check_ok;
    } t_result;

endpackage

/* sv/cpsl_cfg.sv */
// Configuration register file: gains and safety limits.
`timescale 1ns / 1ps

module cpsl_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [cpsl_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [cpsl_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output cpsl_pkg::t_cfg                 o_cfg
);
    import cpsl_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.kp_gain         <= '0;
            r_cfg.ki_gain         <= '0;
            r_cfg.kd_gain         <= '0;
            r_cfg.max_cell_mv     <= MAX_CELL_RST;
            r_cfg.min_cell_mv     <= MIN_CELL_RST;
            r_cfg.max_charge_ma   <= MAX_CHARGE_RST;
            r_cfg.temp_limit_code <= TEMP_LIMIT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_KP:         r_cfg.kp_gain         <= i_cfg_data[GAIN_W-1:0];
                REG_KI:         r_cfg.ki_gain         <= i_cfg_data[GAIN_W-1:0];
                REG_KD:         r_cfg.kd_gain         <= i_cfg_data[GAIN_W-1:0];
                REG_MAX_CELL:   r_cfg.max_cell_mv     <= i_cfg_data[CELL_W-1:0];
                REG_MIN_CELL:   r_cfg.min_cell_mv     <= i_cfg_data[CELL_W-1:0];
                REG_MAX_CHARGE: r_cfg.max_charge_ma   <= i_cfg_data[CHG_MA_W-1:0];
                REG_TEMP_LIMIT: r_cfg.temp_limit_code <= i_cfg_data[TEMP_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

/* sv/cpsl_pid.sv */
// PID step, limit checks and controller state (integral, previous error, latch).
`timescale 1ns / 1ps

module cpsl_pid (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  cpsl_pkg::t_item   i_item,
    input  cpsl_pkg::t_cfg    i_cfg,
    output cpsl_pkg::t_result o_result
);
    import cpsl_pkg::*;

    logic signed [INTEG_W-1:0] r_integral;
    logic signed [ERR_W-1:0]   r_prev_err;
    logic                      r_safe_latch;

    logic signed [INTEG_W-1:0] n_integral;
    logic signed [ERR_W-1:0]   n_prev_err;
    logic                      n_safe_latch;

    logic signed [ERR_W-1:0]          err;
    logic signed [INTEG_W:0]          integ_sum;
    logic signed [INTEG_W-1:0]        integ_c;
    logic signed [DERIV_W-1:0]        deriv;
    logic signed [GAIN_W+ERR_W-1:0]   p_kp;
    logic signed [GAIN_W+INTEG_W-1:0] p_ki;
    logic signed [GAIN_W+DERIV_W-1:0] p_kd;
    logic signed [SUM_W-1:0]          sum;
    logic [DUTY_W-1:0]                duty_pid;
    logic [DUTY_W-1:0]                duty_reg;
    logic                             connected;
    logic                             overheat;
    logic                             overcurrent;
    logic                             check_fail;

    // datapath, independent of the operation code
    always_comb begin
        err = $signed({2'b00, i_item.target_mv}) - $signed({2'b00, i_item.bus_mv});
        integ_sum = $signed({r_integral[INTEG_W-1], r_integral})
                  + $signed({{(INTEG_W+1-ERR_W){err[ERR_W-1]}}, err});
        if (integ_sum > INTEG_LIMIT) begin
            integ_c = INTEG_LIMIT[INTEG_W-1:0];
        end else if (integ_sum < -INTEG_LIMIT) begin
            integ_c = INTEG_W'(-INTEG_LIMIT);
        end else begin
            integ_c = integ_sum[INTEG_W-1:0];
        end
        deriv = $signed({err[ERR_W-1], err}) - $signed({r_prev_err[ERR_W-1], r_prev_err});

        p_kp = $signed(i_cfg.kp_gain) * err;
        p_ki = $signed(i_cfg.ki_gain) * integ_c;
        p_kd = $signed(i_cfg.kd_gain) * deriv;
        sum  = SUM_W'(p_kp) + SUM_W'(p_ki) + SUM_W'(p_kd);

        // positive sum: truncating shift, saturate at full duty
        if (sum[SUM_W-1] || (sum == '0)) begin
            duty_pid = '0;
        end else if (|sum[SUM_W-1:16+DUTY_W]) begin
            duty_pid = DUTY_MAX;
        end else begin
            duty_pid = sum[16+DUTY_W-1:16];
        end

        overcurrent = $signed(i_item.current_ma) > $signed({2'b00, i_item.target_ma});
        if (overcurrent) begin
            duty_reg = (duty_pid > OVERCURRENT_STEP) ? (duty_pid - OVERCURRENT_STEP) : '0;
        end else begin
            duty_reg = duty_pid;
        end

        connected = (i_item.bus_mv > CONNECT_MIN_MV)
                 && (i_item.bus_mv < {i_cfg.max_cell_mv, 2'b00});
        overheat  = i_item.temp_code > i_cfg.temp_limit_code;
        check_fail = (i_item.bus_mv > {2'b00, i_cfg.max_cell_mv})
                  || (i_item.bus_mv < {2'b00, i_cfg.min_cell_mv})
                  || ($signed(i_item.current_ma) > $signed({2'b00, i_cfg.max_charge_ma}));
    end

    // operation select: next state and result
    always_comb begin
        n_integral   = r_integral;
        n_prev_err   = r_prev_err;
        n_safe_latch = r_safe_latch;
        o_result     = '0;
        case (i_item.func)
            FUNC_REGULATE: begin
                if (r_safe_latch && connected) begin
                    o_result.duty_valid = 1'b1;
                    if (overheat) begin
                        n_safe_latch = 1'b0;
                    end else begin
                        o_result.duty = duty_reg;
                        n_integral    = overcurrent ? '0 : integ_c;
                        n_prev_err    = err;
                    end
                end
            end
            FUNC_CHECK: begin
                if (check_fail) begin
                    n_safe_latch        = 1'b0;
                    o_result.duty_valid = 1'b1;
                end else begin
                    o_result.check_ok = 1'b1;
                end
            end
            FUNC_RESET: begin
                n_safe_latch        = 1'b1;
                n_integral          = '0;
                n_prev_err          = '0;
                o_result.duty_valid = 1'b1;
            end
            default: ;
        endcase
        o_result.safe_flag = n_safe_latch;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integral   <= '0;
            r_prev_err   <= '0;
            r_safe_latch <= 1'b1;
        end else if (i_fire) begin
            r_integral   <= n_integral;
            r_prev_err   <= n_prev_err;
            r_safe_latch <= n_safe_latch;
        end
    end

endmodule

/* sv/charger_pid_with_safety_latch_unit.sv */
// Top level: request and result registers around the PID step and config file.
//
//  channel   direction  handshake           payload
//  request   in         i_valid / o_stall   i_func .. i_target_ma
//  result    out        o_valid / i_stall   o_duty, o_duty_valid, o_safe_flag, o_check_ok
//  config    in         i_cfg_we            i_cfg_index, i_cfg_data
//
// One request per cycle while o_stall is low; the result of a taken request is registered.
// The PID step, limit checks and state update run in one pass from the request
// register to the result register, three gain multiplies in parallel.
// Reset is synchronous; it sets the latch, clears the PID state and the gains, and restores the default limits.
// A stalled result holds the request register; o_stall rises only when both are full.
`timescale 1ns / 1ps

module charger_pid_with_safety_latch_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [cpsl_pkg::FUNC_W-1:0]     i_func,
    input  logic [cpsl_pkg::MV_W-1:0]       i_bus_mv,
    input  logic signed [cpsl_pkg::MA_W-1:0] i_current_ma,
    input  logic [cpsl_pkg::TEMP_W-1:0]     i_temp_code,
    input  logic [cpsl_pkg::MV_W-1:0]       i_target_mv,
    input  logic [cpsl_pkg::TGT_MA_W-1:0]   i_target_ma,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [cpsl_pkg::DUTY_W-1:0]     o_duty,
    output logic                           o_duty_valid,
    output logic                           o_safe_flag,
    output logic                           o_check_ok,
    input  logic                           i_cfg_we,
    input  logic [cpsl_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [cpsl_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import cpsl_pkg::*;

    t_cfg    cfg;
    t_item   r_in;
    logic    r_in_valid;
    t_result r_out;
    logic    r_out_valid;
    t_result pid_result;
    logic    accept;
    logic    advance;

    assign advance = r_in_valid && (!r_out_valid || !i_stall);
    assign o_stall = r_in_valid && r_out_valid && i_stall;
    assign accept  = i_valid && !o_stall;

    cpsl_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    cpsl_pid u_pid (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (advance),
        .i_item   (r_in),
        .i_cfg    (cfg),
        .o_result (pid_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in.func       <= i_func;
            r_in.bus_mv     <= i_bus_mv;
            r_in.current_ma <= i_current_ma;
            r_in.temp_code  <= i_temp_code;
            r_in.target_mv  <= i_target_mv;
            r_in.target_ma  <= i_target_ma;
        end
        if (advance) begin
            r_out <= pid_result;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_duty       = r_out.duty;
    assign o_duty_valid = r_out.duty_valid;
    assign o_safe_flag  = r_out.safe_flag;
    assign o_check_ok   = r_out.check_ok;

endmodule

/* tb/tb_top.sv */
// Self-checking testbench for the charger PID step with safety latch.
`timescale 1ns / 1ps

module tb_top;
    import cpsl_pkg::*;

    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
    localparam int HOLD_CYCLES    = 150;
    localparam int DRAIN_CYCLES   = 6;
    localparam int RAND_PER_PHASE = 170;
    localparam int RAND_PHASES    = 6;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_valid = 1'b0;
    logic                  o_stall;
    logic [FUNC_W-1:0]     i_func = '0;
    logic [MV_W-1:0]       i_bus_mv = '0;
    logic signed [MA_W-1:0] i_current_ma = '0;
    logic [TEMP_W-1:0]     i_temp_code = '0;
    logic [MV_W-1:0]       i_target_mv = '0;
    logic [TGT_MA_W-1:0]   i_target_ma = '0;
    logic                  o_valid;
    logic                  i_stall = 1'b0;
    logic [DUTY_W-1:0]     o_duty;
    logic                  o_duty_valid;
    logic                  o_safe_flag;
    logic                  o_check_ok;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    charger_pid_with_safety_latch_unit DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_func       (i_func),
        .i_bus_mv     (i_bus_mv),
        .i_current_ma (i_current_ma),
        .i_temp_code  (i_temp_code),
        .i_target_mv  (i_target_mv),
        .i_target_ma  (i_target_ma),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_duty       (o_duty),
        .o_duty_valid (o_duty_valid),
        .o_safe_flag  (o_safe_flag),
        .o_check_ok   (o_check_ok),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predicted register file, mirrors the power-on values
    longint cfg_kp = 0, cfg_ki = 0, cfg_kd = 0;
    longint cfg_max_cell = MAX_CELL_RST;
    longint cfg_min_cell = MIN_CELL_RST;
    longint cfg_max_charge = MAX_CHARGE_RST;
    longint cfg_temp_limit = TEMP_LIMIT_RST;

    // predicted controller state
    longint acc_mv = 0;
    longint last_err_mv = 0;
    bit     latch_set = 1'b1;

    t_result results_due[$];
    int      mismatch_count = 0;

    int tx_gap_pct = 0;
    int rx_stall_pct = 0;
    int err_bias = 0;
    int hold_requests = 0;
    int holds_served = 0;
    int stall_left = 0;

    function automatic t_result charger_step(input t_item it);
        t_result r;
        longint bus, cur, err, acc, deriv, sum, d, lim;
        r = '0;
        bus = longint'(it.bus_mv);
        cur = longint'($signed(it.current_ma));
        lim = longint'(INTEG_LIMIT);
        case (it.func)
            FUNC_REGULATE: begin
                if (latch_set && bus > longint'(CONNECT_MIN_MV) && bus < 4 * cfg_max_cell) begin
                    if (longint'(it.temp_code) > cfg_temp_limit) begin
                        latch_set = 1'b0;
                        r.duty_valid = 1'b1;
                    end else begin
                        err = longint'(it.target_mv) - bus;
                        acc = acc_mv + err;
                        if (acc > lim) acc = lim;
                        if (acc < -lim) acc = -lim;
                        deriv = err - last_err_mv;
                        sum = cfg_kp * err + cfg_ki * acc + cfg_kd * deriv;
                        d = (sum <= 0) ? 0 : sum / 65536;
                        if (d > longint'(DUTY_MAX)) d = longint'(DUTY_MAX);
                        if (cur > longint'(it.target_ma)) begin
                            d = (d > longint'(OVERCURRENT_STEP)) ?
                                d - longint'(OVERCURRENT_STEP) : 0;
                            acc = 0;
                        end
                        acc_mv = acc;
                        last_err_mv = err;
                        r.duty = d[DUTY_W-1:0];
                        r.duty_valid = 1'b1;
                    end
                end
            end
            FUNC_CHECK: begin
                if (bus > cfg_max_cell || bus < cfg_min_cell || cur > cfg_max_charge) begin
                    latch_set = 1'b0;
                    r.duty_valid = 1'b1;
                end else
                    r.check_ok = 1'b1;
            end
            FUNC_RESET: begin
                latch_set = 1'b1;
                acc_mv = 0;
                last_err_mv = 0;
                r.duty_valid = 1'b1;
            end
            default: ;
        endcase
        r.safe_flag = latch_set;
        return r;
    endfunction

    function automatic void cmp_field(input string name, input int unsigned want,
                                      input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    function automatic void check_result();
        t_result want;
        if (results_due.size() == 0) begin
            $display("%0t: result with no request pending: expected none, actual duty %0d",
                     $time, o_duty);
            mismatch_count++;
        end else begin
            want = results_due.pop_front();
            cmp_field("duty", 32'(want.duty), 32'(o_duty));
            cmp_field("duty_valid", 32'(want.duty_valid), 32'(o_duty_valid));
            cmp_field("safe_flag", 32'(want.safe_flag), 32'(o_safe_flag));
            cmp_field("check_ok", 32'(want.check_ok), 32'(o_check_ok));
        end
    endfunction

    // mostly short gaps, a few long ones
    function automatic int gap_len();
        int r;
        r = $urandom_range(99);
        if (r < 80) return $urandom_range(3, 1);
        if (r < 95) return $urandom_range(8, 4);
        return $urandom_range(40, 15);
    endfunction

    // result side: random stall, plus long hold-offs on demand
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            check_result();
        if (hold_requests != holds_served) begin
            holds_served = holds_served + 1;
            stall_left = HOLD_CYCLES;
        end else if (stall_left == 0 && rx_stall_pct != 0 && $urandom_range(99) < rx_stall_pct)
            stall_left = gap_len();
        if (stall_left > 0) begin
            i_stall <= 1'b1;
            stall_left = stall_left - 1;
        end else
            i_stall <= 1'b0;
    end

    function automatic int clip_mv(input int v);
        if (v < 0) return 0;
        if (v > 32767) return 32767;
        return v;
    endfunction

    function automatic t_item make_req(input logic [FUNC_W-1:0] func, input int bus,
                                       input int cur, input int temp, input int tmv,
                                       input int tma);
        t_item it;
        it.func = func;
        it.bus_mv = bus[MV_W-1:0];
        it.current_ma = cur[MA_W-1:0];
        it.temp_code = temp[TEMP_W-1:0];
        it.target_mv = tmv[MV_W-1:0];
        it.target_ma = tma[TGT_MA_W-1:0];
        return it;
    endfunction

    function automatic t_item rand_req();
        t_item it;
        int pick, hi, lo, bus, tgt, tma, cur;
        pick = $urandom_range(99);
        it.func = FUNC_W'($urandom);
        it.bus_mv = MV_W'($urandom);
        it.current_ma = MA_W'($urandom);
        it.temp_code = TEMP_W'($urandom);
        it.target_mv = MV_W'($urandom);
        it.target_ma = TGT_MA_W'($urandom);
        // a tripped latch is usually re-armed soon
        if (!latch_set && $urandom_range(2) == 0)
            pick = 85;
        if (pick < 70) begin
            it.func = FUNC_REGULATE;
            hi = int'(4 * cfg_max_cell) - 1;
            bus = (hi > 501) ? $urandom_range(hi, 501) : int'(it.bus_mv);
            if (err_bias > 0)
                tgt = bus + $urandom_range(30000, 5000);
            else if (err_bias < 0)
                tgt = bus - $urandom_range(30000, 5000);
            else if ($urandom_range(99) < 85)
                tgt = bus + $urandom_range(2000, 0) - 1000;
            else
                tgt = $urandom_range(32767, 0);
            tma = int'(it.target_ma);
            cur = int'($signed(it.current_ma));
            if ($urandom_range(99) < ((err_bias != 0) ? 97 : 80))
                cur = $urandom_range(tma, 0);
            it.bus_mv = bus[MV_W-1:0];
            it.target_mv = MV_W'(clip_mv(tgt));
            it.current_ma = cur[MA_W-1:0];
            if ($urandom_range(99) < 90)
                it.temp_code = TEMP_W'($urandom_range(int'(cfg_temp_limit), 0));
        end else if (pick < 82) begin
            it.func = FUNC_CHECK;
            lo = int'(cfg_min_cell) - 100;
            hi = int'(cfg_max_cell) + 100;
            it.bus_mv = MV_W'($urandom_range(clip_mv(hi), clip_mv(lo)));
            if ($urandom_range(99) < 90) begin
                cur = $urandom_range(int'(cfg_max_charge) + 20, 0);
                it.current_ma = cur[MA_W-1:0];
            end
        end else if (pick < 90)
            it.func = FUNC_RESET;
        else if (pick >= 96)
            it.func = FUNC_UNUSED;
        return it;
    endfunction

    task automatic tx_idle();
        int n;
        if (tx_gap_pct != 0 && $urandom_range(99) < tx_gap_pct) begin
            n = gap_len();
            i_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic send_req(input t_item it);
        i_valid <= 1'b1;
        i_func <= it.func;
        i_bus_mv <= it.bus_mv;
        i_current_ma <= it.current_ma;
        i_temp_code <= it.temp_code;
        i_target_mv <= it.target_mv;
        i_target_ma <= it.target_ma;
        do @(posedge i_clk); while (o_stall);
        results_due.push_back(charger_step(it));
        tx_idle();
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (results_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        case (idx)
            REG_KP:         cfg_kp = longint'($signed(data));
            REG_KI:         cfg_ki = longint'($signed(data));
            REG_KD:         cfg_kd = longint'($signed(data));
            REG_MAX_CELL:   cfg_max_cell = longint'(data[CELL_W-1:0]);
            REG_MIN_CELL:   cfg_min_cell = longint'(data[CELL_W-1:0]);
            REG_MAX_CHARGE: cfg_max_charge = longint'(data[CHG_MA_W-1:0]);
            REG_TEMP_LIMIT: cfg_temp_limit = longint'(data[TEMP_W-1:0]);
            default: ;
        endcase
    endtask

    task automatic set_regs(input logic [23:0] kp, input logic [23:0] ki,
                            input logic [23:0] kd, input logic [23:0] max_cell,
                            input logic [23:0] min_cell, input logic [23:0] max_charge,
                            input logic [23:0] temp_limit);
        write_reg(REG_KP, kp);
        write_reg(REG_KI, ki);
        write_reg(REG_KD, kd);
        write_reg(REG_MAX_CELL, max_cell);
        write_reg(REG_MIN_CELL, min_cell);
        write_reg(REG_MAX_CHARGE, max_charge);
        write_reg(REG_TEMP_LIMIT, temp_limit);
    endtask

    function automatic logic [23:0] rand_gain();
        case ($urandom_range(2))
            0: return 24'($urandom_range(1 << 18, 1 << 10));
            1: return 24'($urandom);
            default: case ($urandom_range(2))
                0: return 24'h800000;
                1: return 24'h7FFFFF;
                default: return 24'h000000;
            endcase
        endcase
    endfunction

    // power-on registers: zero gains, so any regulate gives duty 0
    task automatic test_power_on_defaults();
        tx_gap_pct = 20;
        rx_stall_pct = 20;
        send_req(make_req(FUNC_REGULATE, 3700, 0, 100, 4000, 2000));
        send_req(make_req(FUNC_CHECK, 3500, 0, 0, 0, 0));
        send_req(make_req(FUNC_REGULATE, 3700, 0, 1023, 3000, 2000));
        send_req(make_req(FUNC_UNUSED, 3700, 0, 0, 0, 0));
        wait_drained();
    endtask

    task automatic test_directed_limits();
        set_regs(24'h010000, 24'h000400, 24'h008000, 4200, 3000, 1000, 800);
        send_req(make_req(FUNC_REGULATE, 3700, 0, 100, 3800, 2000));
        send_req(make_req(FUNC_REGULATE, 501, 0, 0, 32767, 4095));   // saturates high
        send_req(make_req(FUNC_REGULATE, 500, 0, 0, 4000, 4095));    // not connected
        send_req(make_req(FUNC_REGULATE, 16799, 0, 0, 0, 4095));     // negative sum
        send_req(make_req(FUNC_REGULATE, 16800, 0, 0, 4000, 4095));  // not connected
        send_req(make_req(FUNC_REGULATE, 0, 0, 0, 32767, 4095));
        send_req(make_req(FUNC_REGULATE, 3000, 4095, 0, 3100, 0));   // overcurrent
        send_req(make_req(FUNC_REGULATE, 3000, -4096, 800, 3400, 4095));
        send_req(make_req(FUNC_REGULATE, 3000, 0, 801, 3400, 4095)); // over-temperature
        send_req(make_req(FUNC_REGULATE, 3000, 0, 0, 3400, 4095));   // latch clear
        send_req(make_req(FUNC_CHECK, 3500, 500, 0, 0, 0));
        send_req(make_req(FUNC_RESET, 0, 0, 0, 0, 0));
        send_req(make_req(FUNC_CHECK, 4201, 0, 0, 0, 0));
        send_req(make_req(FUNC_RESET, 32767, -1, 1023, 32767, 4095));
        send_req(make_req(FUNC_CHECK, 2999, 0, 0, 0, 0));
        send_req(make_req(FUNC_RESET, 0, 0, 0, 0, 0));
        send_req(make_req(FUNC_CHECK, 3500, 1001, 0, 0, 0));
        send_req(make_req(FUNC_RESET, 0, 0, 0, 0, 0));
        send_req(make_req(FUNC_CHECK, 4200, 1000, 0, 0, 0));
        send_req(make_req(FUNC_UNUSED, 32767, -4096, 1023, 32767, 4095));
        wait_drained();
    endtask

    task automatic test_extreme_settings();
        set_regs(24'h800000, 24'h7FFFFF, 24'h800000, 8191, 0, 4095, 0);
        send_req(make_req(FUNC_REGULATE, 32763, 0, 0, 0, 4095));
        send_req(make_req(FUNC_REGULATE, 32764, 0, 0, 0, 4095));
        send_req(make_req(FUNC_REGULATE, 1000, 0, 1, 0, 4095));
        send_req(make_req(FUNC_RESET, 0, 0, 0, 0, 0));
        send_req(make_req(FUNC_CHECK, 8191, 4095, 0, 0, 0));
        send_req(make_req(FUNC_CHECK, 8192, 0, 0, 0, 0));
        wait_drained();
        // zero cell limit: nothing counts as connected
        set_regs(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 0, 8191, 0, 1023);
        send_req(make_req(FUNC_RESET, 0, 0, 0, 0, 0));
        send_req(make_req(FUNC_REGULATE, 501, 0, 0, 32767, 4095));
        send_req(make_req(FUNC_CHECK, 0, 0, 0, 0, 0));
        wait_drained();
    endtask

    task automatic test_sender_pause();
        set_regs(24'h004000, 24'h000100, 24'h002000, 4200, 3000, 1000, 900);
        send_req(make_req(FUNC_RESET, 0, 0, 0, 0, 0));
        repeat (20) send_req(rand_req());
        wait_drained();
        repeat (20) send_req(rand_req());
        wait_drained();
    endtask

    task automatic test_fill_and_hold();
        tx_gap_pct = 0;
        rx_stall_pct = 0;
        hold_requests++;
        repeat (40) send_req(rand_req());
        wait_drained();
    endtask

    task automatic test_random_settings();
        int p;
        for (p = 0; p < RAND_PHASES; p++) begin
            tx_gap_pct = (p == 0) ? 0 : ((p == 5) ? 50 : 25);
            rx_stall_pct = tx_gap_pct;
            err_bias = (p == 3) ? 1 : ((p == 4) ? -1 : 0);
            if (p == 1)
                set_regs(rand_gain(), rand_gain(), rand_gain(), 8191, 0, 4095, 1023);
            else if (p == 2)
                set_regs(rand_gain(), rand_gain(), rand_gain(), 126, 8191, 0, 0);
            else if (err_bias != 0)
                set_regs(24'($urandom_range(1 << 14, 1 << 8)), 24'($urandom_range(1 << 10, 1)),
                         24'($urandom_range(1 << 14, 0)), 24'($urandom_range(4500, 3000)),
                         24'($urandom_range(3000, 2000)), 24'($urandom),
                         24'($urandom_range(1023, 600)));
            else if ($urandom_range(1) == 0)
                set_regs(rand_gain(), rand_gain(), rand_gain(), 24'($urandom_range(4500, 3000)),
                         24'($urandom_range(3000, 2000)), 24'($urandom),
                         24'($urandom_range(1023, 600)));
            else
                set_regs(rand_gain(), rand_gain(), rand_gain(), 24'($urandom), 24'($urandom),
                         24'($urandom), 24'($urandom));
            send_req(make_req(FUNC_RESET, 0, 0, 0, 0, 0));
            repeat (RAND_PER_PHASE) send_req(rand_req());
            wait_drained();
        end
        err_bias = 0;
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_power_on_defaults();
        test_directed_limits();
        test_extreme_settings();
        test_sender_pause();
        test_fill_and_hold();
        test_random_settings();
        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0 && results_due.size() == 0)
            $display("charger_pid_with_safety_latch_unit test passed");
        else
            $display("charger_pid_with_safety_latch_unit test failed");
        $finish;
    end

    initial begin
        #5000000;
        $display("charger_pid_with_safety_latch_unit test failed");
        $finish;
    end

endmodule
